FILE: src/wrg_pkg.sv
`default_nettype none
package wrg_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;

  localparam int CRD_W   = 12;
  localparam int HGT_W   = 32;
  localparam int DAMP_W  = 17;
  localparam int STR_W   = 31;
  localparam int RAD_W   = 4;
  localparam int ACC_W   = 35;
  localparam int PROD_W  = ACC_W + DAMP_W + 1;
  localparam int RND_SH  = 17;
  localparam int RQ_W    = PROD_W - RND_SH;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  localparam logic [DAMP_W-1:0] DAMP_RST = 17'd64881;
  localparam logic [STR_W-1:0]  STR_RST  = 31'd13107200;
  localparam logic [RAD_W-1:0]  RAD_RST  = 4'd3;

  typedef enum logic [1:0] {
    CMD_WAVE    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_BARRIER = 2'd2,
    CMD_READ    = 2'd3
  } wrg_cmd_t;

  typedef struct packed {
    logic [DAMP_W-1:0] damping;
    logic [STR_W-1:0]  strength;
    logic [RAD_W-1:0]  radius;
  } wrg_cfg_t;

  typedef struct packed {
    wrg_cmd_t   command;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
  } wrg_in_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] shown_height;
    logic signed [HGT_W-1:0] prior_height;
    logic                    is_barrier;
    logic                    saturated;
  } wrg_out_t;

endpackage
`default_nettype wire

FILE: src/wrg_ram.sv
`default_nettype none
module wrg_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra0,
  input  wire logic [$clog2(DEPTH)-1:0] ra1,
  output logic      [DW-1:0]            rd0,
  output logic      [DW-1:0]            rd1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule
`default_nettype wire

FILE: src/wrg_bitmap.sv
`default_nettype none
module wrg_bitmap #(
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic                          rd
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

FILE: src/wrg_ctrl.sv
`default_nettype none
module wrg_ctrl import wrg_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT,
  localparam int AW    = $clog2(CELLS)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wrg_cfg_t        cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wrg_in_t         in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output wrg_out_t             out_data,
  output logic                 a_we,
  output logic [AW-1:0]        a_waddr,
  output logic [HGT_W-1:0]     a_wdata,
  output logic [AW-1:0]        a_ra0,
  output logic [AW-1:0]        a_ra1,
  input  wire logic [HGT_W-1:0] a_rd0,
  input  wire logic [HGT_W-1:0] a_rd1,
  output logic                 b_we,
  output logic [AW-1:0]        b_waddr,
  output logic [HGT_W-1:0]     b_wdata,
  output logic [AW-1:0]        b_ra0,
  output logic [AW-1:0]        b_ra1,
  input  wire logic [HGT_W-1:0] b_rd0,
  input  wire logic [HGT_W-1:0] b_rd1,
  output logic                 m_we,
  output logic [AW-1:0]        m_waddr,
  output logic                 m_wdata,
  output logic [AW-1:0]        m_ra,
  input  wire logic            m_rd
);

  typedef enum logic [14:0] {
    S_CLR    = 15'h0001,
    S_IDLE   = 15'h0002,
    S_WV_RD  = 15'h0004,
    S_WV_WR  = 15'h0008,
    S_ST_A   = 15'h0010,
    S_ST_B   = 15'h0020,
    S_ST_C   = 15'h0040,
    S_ST_MUL = 15'h0080,
    S_ST_WR  = 15'h0100,
    S_ED_RD  = 15'h0200,
    S_ED_WR  = 15'h0400,
    S_BR_WR  = 15'h0800,
    S_RC_RD  = 15'h1000,
    S_RC_CAP = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam crd_t XMAX = CRD_W'(GRID_WIDTH - 1);
  localparam crd_t YMAX = CRD_W'(GRID_HEIGHT - 1);
  localparam crd_t XIN  = CRD_W'(GRID_WIDTH - 2);
  localparam crd_t YIN  = CRD_W'(GRID_HEIGHT - 2);
  localparam crd_t ONE  = CRD_W'(1);
  localparam crd_t ZERO = '0;
  localparam logic signed [HGT_W-1:0] HMAX = {1'b0, {(HGT_W-1){1'b1}}};
  localparam logic signed [HGT_W-1:0] HMIN = {1'b1, {(HGT_W-1){1'b0}}};
  localparam logic signed [HGT_W:0]   WMAX = (HGT_W+1)'(HMAX);
  localparam logic signed [RQ_W-1:0]  RQ_MAX = RQ_W'(HMAX);
  localparam logic signed [RQ_W-1:0]  RQ_MIN = RQ_W'(HMIN);
  localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(65536);
  localparam logic signed [PROD_W-1:0] RND_NEG = PROD_W'(65535);

  function automatic logic [AW-1:0] addr_of(input crd_t cx, input crd_t cy);
    logic [31:0] lin;
    lin = 32'(cy) * 32'(GRID_WIDTH) + 32'(cx);
    return lin[AW-1:0];
  endfunction

  function automatic crd_t clamp_in(input crd_t v, input crd_t hi);
    crd_t res;
    if (v < ONE) res = ONE;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

  state_t   state_r, state_nxt;
  wrg_cmd_t cmd_r, cmd_nxt;
  crd_t     x_r, x_nxt, y_r, y_nxt;
  crd_t     xlo_r, xlo_nxt, xhi_r, xhi_nxt, yhi_r, yhi_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     bar_r, bar_nxt;
  logic                     sat_r, sat_nxt;
  logic                     role_r, role_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic signed [HGT_W-1:0]  rs_shown_r, rs_shown_nxt, rs_prior_r, rs_prior_nxt;
  logic                     rs_bar_r, rs_bar_nxt;
  wrg_out_t                 out_r, out_nxt;
  logic                     ov_r, ov_nxt;

  logic                    wk_we;
  logic [AW-1:0]           wk_waddr, wk_ra, pv_ra0, pv_ra1, cur;
  logic signed [HGT_W-1:0] wk_wdata, wk_rd, pv_rd0, pv_rd1;
  logic                    clearing;

  crd_t px, py, rad, rw, rh, lo_x, hi_x, lo_y, hi_y, t0, t1;
  logic last_x, last_y;
  logic signed [PROD_W-1:0] rsum;
  logic signed [RQ_W-1:0]   rq;
  logic signed [HGT_W:0]    wsum;
  logic                     e_row;

  assign clearing = (state_r == S_CLR);
  assign cur      = addr_of(x_r, y_r);
  assign last_x   = (x_r == xhi_r);
  assign last_y   = (y_r == yhi_r);
  assign e_row    = (y_r == ZERO) || (y_r == YMAX);

  assign a_we    = wk_we & (clearing | ~role_r);
  assign b_we    = wk_we & (clearing | role_r);
  assign a_waddr = wk_waddr;
  assign b_waddr = wk_waddr;
  assign a_wdata = wk_wdata;
  assign b_wdata = wk_wdata;
  assign a_ra0   = role_r ? pv_ra0 : wk_ra;
  assign b_ra0   = role_r ? wk_ra : pv_ra0;
  assign a_ra1   = pv_ra1;
  assign b_ra1   = pv_ra1;
  assign wk_rd   = role_r ? b_rd0 : a_rd0;
  assign pv_rd0  = role_r ? a_rd0 : b_rd0;
  assign pv_rd1  = role_r ? a_rd1 : b_rd1;

  assign rsum = prod_r + (prod_r[PROD_W-1] ? RND_NEG : RND_POS);
  assign rq   = signed'(rsum[PROD_W-1:RND_SH]);
  assign wsum = (HGT_W+1)'(wk_rd) + (HGT_W+1)'(cfg.strength);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    px  = signed'(CRD_W'(in_data.pos_x));
    py  = signed'(CRD_W'(in_data.pos_y));
    rad = signed'(CRD_W'(cfg.radius));
    rw  = signed'(CRD_W'(in_data.rect_width));
    rh  = signed'(CRD_W'(in_data.rect_height));
    if (in_data.command == CMD_WAVE) begin
      t0   = px - rad;
      t1   = px + rad;
      lo_x = (t0 < ZERO) ? ZERO : t0;
      hi_x = (t1 > XMAX) ? XMAX : t1;
      t0   = py - rad;
      t1   = py + rad;
      lo_y = (t0 < ZERO) ? ZERO : t0;
      hi_y = (t1 > YMAX) ? YMAX : t1;
    end else begin
      t0   = px + rw - ONE;
      t1   = py + rh - ONE;
      lo_x = px;
      hi_x = (t0 > XMAX) ? XMAX : t0;
      lo_y = py;
      hi_y = (t1 > YMAX) ? YMAX : t1;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    xlo_nxt      = xlo_r;
    xhi_nxt      = xhi_r;
    yhi_nxt      = yhi_r;
    acc_nxt      = acc_r;
    prod_nxt     = prod_r;
    bar_nxt      = bar_r;
    sat_nxt      = sat_r;
    role_nxt     = role_r;
    clr_nxt      = clr_r;
    rs_shown_nxt = rs_shown_r;
    rs_prior_nxt = rs_prior_r;
    rs_bar_nxt   = rs_bar_r;
    out_nxt      = out_r;
    ov_nxt       = ov_r & ~out_ready;
    wk_we        = 1'b0;
    wk_waddr     = cur;
    wk_wdata     = '0;
    wk_ra        = cur;
    pv_ra0       = cur;
    pv_ra1       = cur;
    m_we         = 1'b0;
    m_waddr      = cur;
    m_wdata      = 1'b0;
    m_ra         = cur;

    unique case (state_r)
      S_CLR: begin
        wk_we    = 1'b1;
        wk_waddr = clr_r;
        m_we     = 1'b1;
        m_waddr  = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data.command;
          sat_nxt      = 1'b0;
          rs_shown_nxt = '0;
          rs_prior_nxt = '0;
          rs_bar_nxt   = 1'b0;
          unique case (in_data.command)
            CMD_WAVE, CMD_BARRIER: begin
              x_nxt   = lo_x;
              y_nxt   = lo_y;
              xlo_nxt = lo_x;
              xhi_nxt = hi_x;
              yhi_nxt = hi_y;
              if (lo_x > hi_x || lo_y > hi_y) state_nxt = S_DONE;
              else if (in_data.command == CMD_WAVE) state_nxt = S_WV_RD;
              else state_nxt = S_BR_WR;
            end
            CMD_STEP: begin
              x_nxt     = ONE;
              y_nxt     = ONE;
              xlo_nxt   = ONE;
              xhi_nxt   = XIN;
              yhi_nxt   = YIN;
              state_nxt = S_ST_A;
            end
            CMD_READ: begin
              x_nxt = px;
              y_nxt = py;
              if (px > XMAX || py > YMAX) state_nxt = S_DONE;
              else state_nxt = S_RC_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WV_RD: begin
        state_nxt = S_WV_WR;
      end
      S_WV_WR: begin
        if (!m_rd) begin
          wk_we = 1'b1;
          if (wsum > WMAX) begin
            wk_wdata = HMAX;
            sat_nxt  = 1'b1;
          end else begin
            wk_wdata = wsum[HGT_W-1:0];
          end
        end
        state_nxt = S_WV_RD;
        if (last_x) begin
          x_nxt = xlo_r;
          y_nxt = y_r + ONE;
          if (last_y) state_nxt = S_DONE;
        end else begin
          x_nxt = x_r + ONE;
        end
      end
      S_BR_WR: begin
        m_we    = 1'b1;
        m_wdata = 1'b1;
        if (last_x) begin
          x_nxt = xlo_r;
          y_nxt = y_r + ONE;
          if (last_y) state_nxt = S_DONE;
        end else begin
          x_nxt = x_r + ONE;
        end
      end
      S_ST_A: begin
        pv_ra0    = addr_of(x_r, y_r - ONE);
        pv_ra1    = addr_of(x_r, y_r + ONE);
        state_nxt = S_ST_B;
      end
      S_ST_B: begin
        pv_ra0    = addr_of(x_r - ONE, y_r);
        pv_ra1    = addr_of(x_r + ONE, y_r);
        acc_nxt   = ACC_W'(pv_rd0) + ACC_W'(pv_rd1) - (ACC_W'(wk_rd) <<< 1);
        bar_nxt   = m_rd;
        state_nxt = S_ST_C;
      end
      S_ST_C: begin
        acc_nxt   = acc_r + ACC_W'(pv_rd0) + ACC_W'(pv_rd1);
        state_nxt = S_ST_MUL;
      end
      S_ST_MUL: begin
        prod_nxt  = PROD_W'(acc_r) * PROD_W'(signed'({1'b0, cfg.damping}));
        state_nxt = S_ST_WR;
      end
      S_ST_WR: begin
        if (!bar_r) begin
          wk_we = 1'b1;
          if (rq > RQ_MAX) begin
            wk_wdata = HMAX;
            sat_nxt  = 1'b1;
          end else if (rq < RQ_MIN) begin
            wk_wdata = HMIN;
            sat_nxt  = 1'b1;
          end else begin
            wk_wdata = rq[HGT_W-1:0];
          end
        end
        state_nxt = S_ST_A;
        if (last_x) begin
          x_nxt = xlo_r;
          y_nxt = y_r + ONE;
          if (last_y) begin
            x_nxt     = ZERO;
            y_nxt     = ZERO;
            state_nxt = S_ED_RD;
          end
        end else begin
          x_nxt = x_r + ONE;
        end
      end
      S_ED_RD: begin
        wk_ra     = addr_of(clamp_in(x_r, XIN), clamp_in(y_r, YIN));
        state_nxt = S_ED_WR;
      end
      S_ED_WR: begin
        wk_we     = 1'b1;
        wk_wdata  = wk_rd;
        state_nxt = S_ED_RD;
        if (x_r == XMAX) begin
          x_nxt = ZERO;
          y_nxt = y_r + ONE;
          if (y_r == YMAX) begin
            role_nxt  = ~role_r;
            state_nxt = S_DONE;
          end
        end else if (e_row) begin
          x_nxt = x_r + ONE;
        end else begin
          x_nxt = XMAX;
        end
      end
      S_RC_RD: begin
        state_nxt = S_RC_CAP;
      end
      S_RC_CAP: begin
        rs_shown_nxt = wk_rd;
        rs_prior_nxt = pv_rd0;
        rs_bar_nxt   = m_rd;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          out_nxt.shown_height = rs_shown_r;
          out_nxt.prior_height = rs_prior_r;
          out_nxt.is_barrier   = rs_bar_r;
          out_nxt.saturated    = sat_r;
          ov_nxt               = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      role_r  <= 1'b0;
      ov_r    <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      role_r  <= role_nxt;
      ov_r    <= ov_nxt;
      sat_r   <= sat_nxt;
    end
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    xlo_r      <= xlo_nxt;
    xhi_r      <= xhi_nxt;
    yhi_r      <= yhi_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    bar_r      <= bar_nxt;
    rs_shown_r <= rs_shown_nxt;
    rs_prior_r <= rs_prior_nxt;
    rs_bar_r   <= rs_bar_nxt;
    out_r      <= out_nxt;
  end

  a_role_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (role_r != $past(role_r)) |-> $past(state_r == S_ED_WR))
    else $error("bank roles swapped outside the end of a step");

  a_barrier_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ST_WR && bar_r) |-> !wk_we)
    else $error("step wrote a barrier cell");

  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (cmd_r == CMD_BARRIER || cmd_r == CMD_READ)) |-> !sat_r)
    else $error("saturation flagged on a barrier or read request");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> (!wk_we && !m_we))
    else $error("memory write while no request is in progress");

endmodule
`default_nettype wire

FILE: src/wave_ripple_grid_step_top.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data   (wrg_in_t)
// out     | output    | out_valid / out_ready| out_data  (wrg_out_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request at a time through a sequencer over three single-write memories.
// Wave: S_WV_RD then S_WV_WR per clipped cell; barrier: S_BR_WR per clipped cell;
// read: S_RC_RD then S_RC_CAP. Step: S_ST_A, S_ST_B, S_ST_C, S_ST_MUL, S_ST_WR per
// interior cell (dual-read prev bank), then S_ED_RD and S_ED_WR per edge cell.
// After reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells holds in_ready low.
// A result waiting on out_ready holds the next request only at its end.
`default_nettype none
module wave_ripple_grid_step_top import wrg_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire wrg_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output wrg_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  wrg_cfg_t cfg_r;

  logic             a_we, b_we, m_we, m_wdata, m_rd;
  logic [AW-1:0]    a_waddr, a_ra0, a_ra1, b_waddr, b_ra0, b_ra1, m_waddr, m_ra;
  logic [HGT_W-1:0] a_wdata, a_rd0, a_rd1, b_wdata, b_rd0, b_rd1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.damping  <= DAMP_RST;
      cfg_r.strength <= STR_RST;
      cfg_r.radius   <= RAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DAMPING:  cfg_r.damping  <= cfg_data[DAMP_W-1:0];
        CFG_STRENGTH: cfg_r.strength <= cfg_data[STR_W-1:0];
        CFG_RADIUS:   cfg_r.radius   <= cfg_data[RAD_W-1:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  wrg_ctrl #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .a_we      (a_we),
    .a_waddr   (a_waddr),
    .a_wdata   (a_wdata),
    .a_ra0     (a_ra0),
    .a_ra1     (a_ra1),
    .a_rd0     (a_rd0),
    .a_rd1     (a_rd1),
    .b_we      (b_we),
    .b_waddr   (b_waddr),
    .b_wdata   (b_wdata),
    .b_ra0     (b_ra0),
    .b_ra1     (b_ra1),
    .b_rd0     (b_rd0),
    .b_rd1     (b_rd1),
    .m_we      (m_we),
    .m_waddr   (m_waddr),
    .m_wdata   (m_wdata),
    .m_ra      (m_ra),
    .m_rd      (m_rd)
  );

  wrg_ram #(.DW(HGT_W), .DEPTH(CELLS)) u_bank_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .ra0   (a_ra0),
    .ra1   (a_ra1),
    .rd0   (a_rd0),
    .rd1   (a_rd1)
  );

  wrg_ram #(.DW(HGT_W), .DEPTH(CELLS)) u_bank_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .ra0   (b_ra0),
    .ra1   (b_ra1),
    .rd0   (b_rd0),
    .rd1   (b_rd1)
  );

  wrg_bitmap #(.DEPTH(CELLS)) u_barrier (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .ra    (m_ra),
    .rd    (m_rd)
  );

endmodule
`default_nettype wire
